@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned DefDelayBits   = 16;
  localparam int unsigned HalfPeriodBits = 16;
  localparam logic [HalfPeriodBits-1:0] HalfPeriodReset = 16'd50;
  localparam int unsigned BitsPerByte    = 8;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_READ,
    OP_STATUS
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_RS_REL,
    PH_RS_D1,
    PH_RS_WSCL,
    PH_RS_D2,
    PH_ST_CHK,
    PH_ST_D,
    PH_BIT_SET,
    PH_BIT_D1,
    PH_BIT_WSCL,
    PH_BIT_D2,
    PH_SP_SDA,
    PH_SP_D1,
    PH_SP_WSCL,
    PH_SP_D2,
    PH_SP_CHK,
    PH_SP_D3
  } phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       send_start;
    logic       send_stop;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_received;
    logic       arbitration_lost;
    logic       clock_stretch_wait;
    logic       command_rejected;
  } res_t;

  // Classified request as held in the queue.
  typedef struct packed {
    op_e        op;
    logic       start;
    logic       stop;
    logic       nack;
    logic [7:0] tx_byte;
    logic       scl;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic read;
    logic start;
    logic stop;
    logic nack;
  } flags_t;

endpackage

@@ rtl/i2c_master_byte_engine_top.sv @@
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_req_i   (req_t)
// out     | output    | out_valid_o / out_ready_i | out_res_o  (res_t)
// cfg     | input     | cfg_we_i, no wait         | cfg_wdata_i (half period ticks)
//
// One request per clock sustained while the output is not stalled. A request accepted at
// an edge goes into the two-entry request queue, is evaluated from there into the result
// register, and is offered from that register until the output takes it.
// The bus sequencer in the engine retires one request per cycle unless the output stalls.
// Reset: idle, both lines released, half period 50 ticks.
// A stalled output holds the result register; the queue keeps accepting until full.
`timescale 1ns / 1ps

module i2c_master_byte_engine_top #(
  parameter int unsigned DelayBits = i2cm_pkg::DefDelayBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [i2cm_pkg::HalfPeriodBits-1:0] cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  i2cm_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output i2cm_pkg::res_t                      out_res_o
);

  i2cm_pkg::item_t front_item, queue_item;
  logic            queue_full, queue_nonempty, queue_pop;

  i2cm_front u_front (
    .req_i  (in_req_i),
    .item_o (front_item)
  );

  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .nonempty_o  (queue_nonempty),
    .pop_data_o  (queue_item)
  );

  assign in_ready_o = ~queue_full;

  i2cm_engine #(
    .DelayBits (DelayBits)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (queue_nonempty),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res_o)
  );

endmodule

@@ rtl/i2cm_front.sv @@
`timescale 1ns / 1ps

module i2cm_front (
  input  i2cm_pkg::req_t  req_i,
  output i2cm_pkg::item_t item_o
);

  always_comb begin
    item_o.start   = req_i.send_start;
    item_o.stop    = req_i.send_stop;
    item_o.nack    = req_i.ack_to_send;
    item_o.tx_byte = req_i.tx_byte;
    item_o.scl     = req_i.scl_in;
    item_o.sda     = req_i.sda_in;
    unique case (i2cm_pkg::req_type_e'(req_i.req_type))
      i2cm_pkg::REQ_TICK:  item_o.op = i2cm_pkg::OP_TICK;
      i2cm_pkg::REQ_WRITE: item_o.op = i2cm_pkg::OP_WRITE;
      i2cm_pkg::REQ_READ:  item_o.op = i2cm_pkg::OP_READ;
      default:             item_o.op = i2cm_pkg::OP_STATUS;
    endcase
  end

endmodule

@@ rtl/i2cm_queue.sv @@
`timescale 1ns / 1ps

module i2cm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::item_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output i2cm_pkg::item_t pop_data_o
);

  localparam int unsigned PtrBits = (i2cm_pkg::QueueDepth > 1) ?
                                    $clog2(i2cm_pkg::QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(i2cm_pkg::QueueDepth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(i2cm_pkg::QueueDepth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(i2cm_pkg::QueueDepth);

  i2cm_pkg::item_t    mem_q [i2cm_pkg::QueueDepth];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign nonempty_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & nonempty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/i2cm_engine.sv @@
`timescale 1ns / 1ps

module i2cm_engine #(
  parameter int unsigned DelayBits = i2cm_pkg::DefDelayBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [i2cm_pkg::HalfPeriodBits-1:0]   cfg_wdata_i,
  input  logic                                  item_valid_i,
  input  i2cm_pkg::item_t                       item_i,
  output logic                                  item_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output i2cm_pkg::res_t                        out_res_o
);

  localparam logic [3:0] ByteBits = 4'(i2cm_pkg::BitsPerByte);

  logic [i2cm_pkg::HalfPeriodBits-1:0] half_q;
  i2cm_pkg::phase_e   phase_q, phase_d;
  logic [3:0]         bit_idx_q, bit_idx_d;
  logic [DelayBits-1:0] delay_q, delay_d, delay_dec, delay_load;
  logic [7:0]         shift_q, shift_d;
  logic               started_q, started_d;
  i2cm_pkg::flags_t   flags_q, flags_d;
  logic               scl_low_q, scl_low_d;
  logic               sda_low_q, sda_low_d;
  logic               out_valid_q;
  i2cm_pkg::res_t     res_q, res_d;

  logic fire, is_cmd, cmd_take, tick, delay_done, reading, wval, past_data, finish;

  assign fire       = item_valid_i & (~out_valid_q | out_ready_i);
  assign item_pop_o = fire;
  assign is_cmd     = (item_i.op == i2cm_pkg::OP_WRITE) || (item_i.op == i2cm_pkg::OP_READ);
  assign cmd_take   = fire & is_cmd & (phase_q == i2cm_pkg::PH_IDLE);
  assign tick       = fire & (item_i.op == i2cm_pkg::OP_TICK) &
                      (phase_q != i2cm_pkg::PH_IDLE);

  assign delay_done = (delay_q <= DelayBits'(1));
  assign delay_dec  = delay_done ? '0 : delay_q - 1'b1;
  assign delay_load = (DelayBits'(half_q) == '0) ? DelayBits'(1) : DelayBits'(half_q);

  assign past_data  = (bit_idx_q >= ByteBits);
  assign reading    = flags_q.read ? ~past_data : past_data;
  assign wval       = flags_q.read ? flags_q.nack : shift_q[7];

  assign finish = tick & delay_done &
                  (((phase_q == i2cm_pkg::PH_BIT_D2) & past_data & ~flags_q.stop) |
                   (phase_q == i2cm_pkg::PH_SP_D3));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (cmd_take) begin
      if (item_i.start) begin
        phase_d = started_q ? i2cm_pkg::PH_RS_REL : i2cm_pkg::PH_ST_CHK;
      end else begin
        phase_d = i2cm_pkg::PH_BIT_SET;
      end
    end else if (tick) begin
      unique case (phase_q)
        i2cm_pkg::PH_RS_REL:   phase_d = i2cm_pkg::PH_RS_D1;
        i2cm_pkg::PH_RS_D1:    if (delay_done) phase_d = i2cm_pkg::PH_RS_WSCL;
        i2cm_pkg::PH_RS_WSCL:  if (item_i.scl) phase_d = i2cm_pkg::PH_RS_D2;
        i2cm_pkg::PH_RS_D2:    if (delay_done) phase_d = i2cm_pkg::PH_ST_CHK;
        i2cm_pkg::PH_ST_CHK:   phase_d = i2cm_pkg::PH_ST_D;
        i2cm_pkg::PH_ST_D:     if (delay_done) phase_d = i2cm_pkg::PH_BIT_SET;
        i2cm_pkg::PH_BIT_SET:  phase_d = i2cm_pkg::PH_BIT_D1;
        i2cm_pkg::PH_BIT_D1:   if (delay_done) phase_d = i2cm_pkg::PH_BIT_WSCL;
        i2cm_pkg::PH_BIT_WSCL: if (item_i.scl) phase_d = i2cm_pkg::PH_BIT_D2;
        i2cm_pkg::PH_BIT_D2: begin
          if (delay_done) begin
            if (!past_data) begin
              phase_d = i2cm_pkg::PH_BIT_SET;
            end else if (flags_q.stop) begin
              phase_d = i2cm_pkg::PH_SP_SDA;
            end else begin
              phase_d = i2cm_pkg::PH_IDLE;
            end
          end
        end
        i2cm_pkg::PH_SP_SDA:   phase_d = i2cm_pkg::PH_SP_D1;
        i2cm_pkg::PH_SP_D1:    if (delay_done) phase_d = i2cm_pkg::PH_SP_WSCL;
        i2cm_pkg::PH_SP_WSCL:  if (item_i.scl) phase_d = i2cm_pkg::PH_SP_D2;
        i2cm_pkg::PH_SP_D2:    if (delay_done) phase_d = i2cm_pkg::PH_SP_CHK;
        i2cm_pkg::PH_SP_CHK:   phase_d = i2cm_pkg::PH_SP_D3;
        i2cm_pkg::PH_SP_D3:    if (delay_done) phase_d = i2cm_pkg::PH_IDLE;
        default:               phase_d = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    bit_idx_d = bit_idx_q;
    delay_d   = delay_q;
    shift_d   = shift_q;
    started_d = started_q;
    flags_d   = flags_q;
    scl_low_d = scl_low_q;
    sda_low_d = sda_low_q;
    res_d     = '0;

    res_d.command_rejected = fire & is_cmd & (phase_q != i2cm_pkg::PH_IDLE);

    if (cmd_take) begin
      flags_d.read  = (item_i.op == i2cm_pkg::OP_READ);
      flags_d.start = item_i.start;
      flags_d.stop  = item_i.stop;
      flags_d.nack  = item_i.nack;
      shift_d       = (item_i.op == i2cm_pkg::OP_WRITE) ? item_i.tx_byte : '0;
      bit_idx_d     = '0;
    end else if (tick) begin
      unique case (phase_q)
        i2cm_pkg::PH_RS_REL: begin
          sda_low_d = 1'b0;
          delay_d   = delay_load;
        end
        i2cm_pkg::PH_RS_D1, i2cm_pkg::PH_RS_D2, i2cm_pkg::PH_BIT_D1,
        i2cm_pkg::PH_SP_D1: begin
          delay_d = delay_dec;
        end
        i2cm_pkg::PH_RS_WSCL, i2cm_pkg::PH_SP_WSCL: begin
          scl_low_d = 1'b0;
          if (!item_i.scl) begin
            res_d.clock_stretch_wait = 1'b1;
          end else begin
            delay_d = delay_load;
          end
        end
        i2cm_pkg::PH_ST_CHK: begin
          res_d.arbitration_lost = ~item_i.sda;
          sda_low_d = 1'b1;
          delay_d   = delay_load;
        end
        i2cm_pkg::PH_ST_D: begin
          delay_d = delay_dec;
          if (delay_done) begin
            scl_low_d = 1'b1;
            started_d = 1'b1;
          end
        end
        i2cm_pkg::PH_BIT_SET: begin
          sda_low_d = reading ? 1'b0 : ~wval;
          delay_d   = delay_load;
        end
        i2cm_pkg::PH_BIT_WSCL: begin
          scl_low_d = 1'b0;
          if (!item_i.scl) begin
            res_d.clock_stretch_wait = 1'b1;
          end else begin
            if (reading) begin
              shift_d = {shift_q[6:0], item_i.sda};
            end else begin
              res_d.arbitration_lost = wval & ~item_i.sda;
              if (!flags_q.read) begin
                shift_d = {shift_q[6:0], 1'b0};
              end
            end
            delay_d = delay_load;
          end
        end
        i2cm_pkg::PH_BIT_D2: begin
          delay_d = delay_dec;
          if (delay_done) begin
            scl_low_d = 1'b1;
            if (!past_data) begin
              bit_idx_d = bit_idx_q + 1'b1;
            end
          end
        end
        i2cm_pkg::PH_SP_SDA: begin
          sda_low_d = 1'b1;
          delay_d   = delay_load;
        end
        i2cm_pkg::PH_SP_D2: begin
          delay_d = delay_dec;
          if (delay_done) begin
            sda_low_d = 1'b0;
          end
        end
        i2cm_pkg::PH_SP_CHK: begin
          res_d.arbitration_lost = ~item_i.sda;
          delay_d = delay_load;
        end
        i2cm_pkg::PH_SP_D3: begin
          delay_d = delay_dec;
          if (delay_done) begin
            started_d = 1'b0;
          end
        end
        default: begin
          delay_d = delay_q;
        end
      endcase
    end

    if (finish) begin
      res_d.done_res      = 1'b1;
      res_d.rx_byte       = flags_q.read ? shift_q : '0;
      res_d.nack_received = ~flags_q.read & shift_q[0];
    end

    res_d.scl_drive_low = scl_low_d;
    res_d.sda_drive_low = sda_low_d;
    res_d.busy_res      = (phase_d != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= i2cm_pkg::HalfPeriodReset;
      phase_q     <= i2cm_pkg::PH_IDLE;
      bit_idx_q   <= '0;
      delay_q     <= '0;
      shift_q     <= '0;
      started_q   <= 1'b0;
      flags_q     <= '0;
      scl_low_q   <= 1'b0;
      sda_low_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q   <= phase_d;
        bit_idx_q <= bit_idx_d;
        delay_q   <= delay_d;
        shift_q   <= shift_d;
        started_q <= started_d;
        flags_q   <= flags_d;
        scl_low_q <= scl_low_d;
        sda_low_q <= sda_low_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

@@ rtl/i2cm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input i2cm_pkg::res_t out_res_o
);

  logic out_stall, out_done, out_rej, out_nodone, rej_quiet, data_clear;

  assign out_stall  = out_valid_o & ~out_ready_i;
  assign out_done   = out_valid_o & out_res_o.done_res;
  assign out_rej    = out_valid_o & out_res_o.command_rejected;
  assign out_nodone = out_valid_o & ~out_res_o.done_res;
  assign rej_quiet  = ~out_res_o.done_res & ~out_res_o.arbitration_lost &
                      ~out_res_o.clock_stretch_wait;
  assign data_clear = (out_res_o.rx_byte == 8'd0) & ~out_res_o.nack_received;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_res_o), "held")
  `ASSERT_SAME(a_done_idle, clk_i, rst_ni, out_done, !out_res_o.busy_res, "done while busy")
  `ASSERT_SAME(a_reject_clean, clk_i, rst_ni, out_rej, rej_quiet, "rejected request moved")
  `ASSERT_SAME(a_data_on_done, clk_i, rst_ni, out_nodone, data_clear, "data without done")

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int ReqBits = $bits(req_t);
  localparam int IdleLimit = 2000;
  localparam int MaxPrinted = 40;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [HalfPeriodBits-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  req_t                      in_req_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  res_t                      out_res_o;

  i2c_master_byte_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  // engine mirror
  logic [15:0] half_per;
  phase_e      ph;
  logic [3:0]  bit_idx;
  logic [15:0] dly;
  logic [7:0]  shreg;
  logic        started;
  flags_t      flags;
  logic        pin_scl;
  logic        pin_sda;

  res_t expected_res[$];
  bit   calm;
  int   n_errors;
  int   n_items;
  int   n_results;
  int   n_done;
  int   n_rejected;
  int   n_arb;
  int   n_stretch;
  int   idle_cycles;

  function automatic logic reading_bit();
    return flags.read ? (bit_idx < 4'd8) : (bit_idx >= 4'd8);
  endfunction

  function automatic logic out_bit();
    return flags.read ? flags.nack : shreg[7];
  endfunction

  function automatic void load_dly();
    dly = (half_per == '0) ? 16'd1 : half_per;
  endfunction

  function automatic logic dly_done();
    if (dly <= 16'd1) begin
      dly = '0;
      return 1'b1;
    end
    dly = dly - 16'd1;
    return 1'b0;
  endfunction

  function automatic res_t step_engine(input req_t r);
    res_t res;
    logic fin;
    res = '0;
    fin = 1'b0;
    if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
      if (ph != PH_IDLE) begin
        res.command_rejected = 1'b1;
      end else begin
        flags.read  = (r.req_type == REQ_READ);
        flags.start = r.send_start;
        flags.stop  = r.send_stop;
        flags.nack  = r.ack_to_send;
        shreg = flags.read ? 8'h00 : r.tx_byte;
        bit_idx = '0;
        if (flags.start) ph = started ? PH_RS_REL : PH_ST_CHK;
        else ph = PH_BIT_SET;
      end
    end else if (r.req_type == REQ_TICK && ph != PH_IDLE) begin
      case (ph)
        PH_RS_REL: begin
          pin_sda = 1'b0;
          load_dly();
          ph = PH_RS_D1;
        end
        PH_RS_D1: if (dly_done()) ph = PH_RS_WSCL;
        PH_RS_WSCL: begin
          pin_scl = 1'b0;
          if (!r.scl_in) res.clock_stretch_wait = 1'b1;
          else begin
            load_dly();
            ph = PH_RS_D2;
          end
        end
        PH_RS_D2: if (dly_done()) ph = PH_ST_CHK;
        PH_ST_CHK: begin
          if (!r.sda_in) res.arbitration_lost = 1'b1;
          pin_sda = 1'b1;
          load_dly();
          ph = PH_ST_D;
        end
        PH_ST_D: begin
          if (dly_done()) begin
            pin_scl = 1'b1;
            started = 1'b1;
            ph = PH_BIT_SET;
          end
        end
        PH_BIT_SET: begin
          pin_sda = reading_bit() ? 1'b0 : ~out_bit();
          load_dly();
          ph = PH_BIT_D1;
        end
        PH_BIT_D1: if (dly_done()) ph = PH_BIT_WSCL;
        PH_BIT_WSCL: begin
          pin_scl = 1'b0;
          if (!r.scl_in) begin
            res.clock_stretch_wait = 1'b1;
          end else begin
            if (reading_bit()) begin
              shreg = {shreg[6:0], r.sda_in};
            end else begin
              if (out_bit() && !r.sda_in) res.arbitration_lost = 1'b1;
              if (!flags.read) shreg = {shreg[6:0], 1'b0};
            end
            load_dly();
            ph = PH_BIT_D2;
          end
        end
        PH_BIT_D2: begin
          if (dly_done()) begin
            pin_scl = 1'b1;
            if (bit_idx >= 4'd8) begin
              if (flags.stop) ph = PH_SP_SDA;
              else fin = 1'b1;
            end else begin
              bit_idx = bit_idx + 4'd1;
              ph = PH_BIT_SET;
            end
          end
        end
        PH_SP_SDA: begin
          pin_sda = 1'b1;
          load_dly();
          ph = PH_SP_D1;
        end
        PH_SP_D1: if (dly_done()) ph = PH_SP_WSCL;
        PH_SP_WSCL: begin
          pin_scl = 1'b0;
          if (!r.scl_in) res.clock_stretch_wait = 1'b1;
          else begin
            load_dly();
            ph = PH_SP_D2;
          end
        end
        PH_SP_D2: begin
          if (dly_done()) begin
            pin_sda = 1'b0;
            ph = PH_SP_CHK;
          end
        end
        PH_SP_CHK: begin
          if (!r.sda_in) res.arbitration_lost = 1'b1;
          load_dly();
          ph = PH_SP_D3;
        end
        PH_SP_D3: begin
          if (dly_done()) begin
            started = 1'b0;
            fin = 1'b1;
          end
        end
        default: ph = PH_IDLE;
      endcase
      if (fin) begin
        res.done_res = 1'b1;
        if (flags.read) res.rx_byte = shreg;
        else res.nack_received = shreg[0];
        ph = PH_IDLE;
      end
    end
    res.scl_drive_low = pin_scl;
    res.sda_drive_low = pin_sda;
    res.busy_res = (ph != PH_IDLE);
    return res;
  endfunction

  // Open-drain bus: a pulled line reads low; a target stretches SCL now and
  // then, drives data and ack bits, and rarely upsets a released SDA.
  function automatic req_t bus_tick();
    req_t t;
    logic target_bit;
    t = req_t'(ReqBits'($urandom));
    t.req_type = REQ_TICK;
    t.scl_in = !pin_scl && ($urandom_range(0, 99) >= 10);
    target_bit = (ph inside {PH_BIT_SET, PH_BIT_D1, PH_BIT_WSCL, PH_BIT_D2}) && reading_bit();
    if (pin_sda) t.sda_in = 1'b0;
    else if (target_bit) t.sda_in = 1'($urandom_range(0, 1));
    else t.sda_in = ($urandom_range(0, 99) >= 3);
    return t;
  endfunction

  function automatic req_t make_cmd(input req_type_e kind, input logic start,
                                    input logic stop, input logic [7:0] data,
                                    input logic nack);
    req_t c;
    c = req_t'(ReqBits'($urandom));
    c.req_type = kind;
    c.send_start = start;
    c.send_stop = stop;
    c.tx_byte = data;
    c.ack_to_send = nack;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (n_errors < MaxPrinted)
      $display("%0t: result %0d: %s expected %0h got %0h", $realtime, n_results, what,
               want, got);
    n_errors++;
  endtask

  task automatic send_req(input req_t r);
    res_t res;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = step_engine(r);
    expected_res.push_back(res);
    n_items++;
    n_done += res.done_res;
    n_rejected += res.command_rejected;
    n_arb += res.arbitration_lost;
    n_stretch += res.clock_stretch_wait;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_half_period(input logic [15:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    half_per = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_transfer();
    while (ph != PH_IDLE) send_req(bus_tick());
  endtask

  task automatic test_idle_requests();
    req_t t;
    t = req_t'(ReqBits'($urandom));
    t.req_type = REQ_NOP;
    send_req(t);
    t = '0;
    send_req(t);
    t = '1;
    t.req_type = REQ_TICK;
    send_req(t);
    t.req_type = REQ_NOP;
    send_req(t);
  endtask

  task automatic test_write_bytes();
    req_t t;
    set_half_period(16'd1);
    send_req(make_cmd(REQ_WRITE, 1'b1, 1'b0, 8'h00, 1'b1));
    send_req(make_cmd(REQ_READ, 1'b1, 1'b1, 8'hff, 1'b0));
    t = '1;
    t.req_type = REQ_NOP;
    send_req(t);
    run_transfer();
    // no start, stop after
    send_req(make_cmd(REQ_WRITE, 1'b0, 1'b1, 8'hff, 1'b0));
    run_transfer();
  endtask

  task automatic test_read_and_restart();
    set_half_period(16'd0);
    send_req(make_cmd(REQ_WRITE, 1'b1, 1'b0, 8'ha5, 1'b0));
    run_transfer();
    // repeated start on a read
    send_req(make_cmd(REQ_READ, 1'b1, 1'b0, 8'h00, 1'b0));
    run_transfer();
    send_req(make_cmd(REQ_READ, 1'b0, 1'b1, 8'h5a, 1'b1));
    run_transfer();
  endtask

  task automatic test_long_half_period();
    bit seen_long;
    seen_long = 1'b0;
    set_half_period(16'd160);
    send_req(make_cmd(REQ_WRITE, 1'b1, 1'b1, 8'h3c, 1'b0));
    calm = 1'b1;
    while (!(seen_long && dly == '0)) begin
      send_req(bus_tick());
      if (dly > 16'd100) seen_long = 1'b1;
    end
    calm = 1'b0;
    // shorten the rest of the transfer, it picks up the new value at next load
    set_half_period(16'd2);
    run_transfer();
  endtask

  task automatic test_random_traffic();
    logic [15:0] periods[5];
    req_t t;
    int roll;
    periods[0] = 16'd1;
    periods[1] = 16'd2;
    periods[2] = 16'd0;
    periods[3] = 16'd3;
    periods[4] = 16'($urandom_range(1, 4));
    for (int p = 0; p < 5; p++) begin
      set_half_period(periods[p]);
      calm = (p == 1);
      for (int i = 0; i < 50; i++) begin
        if (p == 3 && i == 25) drain();
        roll = $urandom_range(0, 99);
        if (ph == PH_IDLE) begin
          if (roll < 70) begin
            send_req(make_cmd($urandom_range(0, 1) ? REQ_READ : REQ_WRITE,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom), 1'($urandom_range(0, 1))));
          end else begin
            t = req_t'(ReqBits'($urandom));
            t.req_type = (roll < 85) ? REQ_NOP : REQ_TICK;
            send_req(t);
          end
        end else if (roll < 84) begin
          send_req(bus_tick());
        end else begin
          t = req_t'(ReqBits'($urandom));
          if (roll < 90) t.req_type = REQ_TICK;
          else if (roll < 96) t.req_type = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
          else t.req_type = REQ_NOP;
          send_req(t);
        end
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", 0, out_res_o);
      end else begin
        want = expected_res.pop_front();
        if (out_res_o.scl_drive_low !== want.scl_drive_low)
          report_mismatch("scl_drive_low", want.scl_drive_low, out_res_o.scl_drive_low);
        if (out_res_o.sda_drive_low !== want.sda_drive_low)
          report_mismatch("sda_drive_low", want.sda_drive_low, out_res_o.sda_drive_low);
        if (out_res_o.busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, out_res_o.busy_res);
        if (out_res_o.done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, out_res_o.done_res);
        if (out_res_o.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", want.rx_byte, out_res_o.rx_byte);
        if (out_res_o.nack_received !== want.nack_received)
          report_mismatch("nack_received", want.nack_received, out_res_o.nack_received);
        if (out_res_o.arbitration_lost !== want.arbitration_lost)
          report_mismatch("arbitration_lost", want.arbitration_lost,
                          out_res_o.arbitration_lost);
        if (out_res_o.clock_stretch_wait !== want.clock_stretch_wait)
          report_mismatch("clock_stretch_wait", want.clock_stretch_wait,
                          out_res_o.clock_stretch_wait);
        if (out_res_o.command_rejected !== want.command_rejected)
          report_mismatch("command_rejected", want.command_rejected,
                          out_res_o.command_rejected);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("i2c_master_byte_engine_top test failed");
        $finish;
      end
    end
  end

  initial begin
    half_per = HalfPeriodReset;
    ph = PH_IDLE;
    bit_idx = '0;
    dly = '0;
    shreg = '0;
    started = 1'b0;
    flags = '0;
    pin_scl = 1'b0;
    pin_sda = 1'b0;
    calm = 1'b0;
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    n_done = 0;
    n_rejected = 0;
    n_arb = 0;
    n_stretch = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_requests();
    test_write_bytes();
    test_read_and_restart();
    test_long_half_period();
    test_random_traffic();

    drain();
    repeat (4) @(posedge clk_i);
    $display("%0d requests, %0d results: %0d bytes done, %0d commands rejected",
             n_items, n_results, n_done, n_rejected);
    $display("%0d arbitration losses, %0d stretch waits, half periods 0, 1..4, 160",
             n_arb, n_stretch);
    if (n_errors == 0) begin
      $display("i2c_master_byte_engine_top test passed");
    end else begin
      $display("i2c_master_byte_engine_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_engine.sv
rtl/i2c_master_byte_engine_top.sv
rtl/i2cm_checker.sv
tb/testbench.sv
